[src/lrs_pkg.sv]
// Package for the LSD radix sort core: controller state and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package lrs_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_CNT,
    ST_SCAN,
    ST_SCAT,
    ST_EMIT
  } lrs_state_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic cnt;
    logic scan;
    logic scat;
    logic emit;
    logic first;
    logic last_pass;
    logic step;
  } lrs_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic bkt_end;
    logic pass_end;
    logic empty;
    logic out_busy;
  } lrs_sts_t;

endpackage
`default_nettype wire

[src/lrs_stream_if.sv]
// Valid/ready stream interface with a key and a last flag.
// No dependencies.
`default_nettype none
interface lrs_stream_if #(
  parameter int unsigned KeyW = 32
);
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;
  logic            last;

  modport source (output valid, key, last, input ready);
  modport sink   (input valid, key, last, output ready);
endinterface
`default_nettype wire

[src/lrs_ctrl.sv]
// Controller state machine for the radix sort core.
// Depends on lrs_pkg.
`default_nettype none
module lrs_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_last_i,
  output logic               in_ready_o,
  input  lrs_pkg::lrs_sts_t  sts_i,
  output lrs_pkg::lrs_cmd_t  cmd_o
);
  import lrs_pkg::*;

  lrs_state_e state_q, state_d;
  logic       first_q, first_d;
  logic [1:0] ph_q, ph_d;
  logic       ph_last;
  logic       step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      first_q <= 1'b1;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      ph_q    <= ph_d;
    end
  end

  // Per-item phase: read key, read table, then act (count and scatter; clear, scan and emit use fewer phases).
  always_comb begin
    ph_last = 1'b0;
    unique case (state_q)
      ST_CLR:           ph_last = 1'b1;
      ST_SCAN, ST_EMIT: ph_last = (ph_q == 2'd1);
      ST_CNT, ST_SCAT:  ph_last = (ph_q == 2'd2);
      default:          ph_last = 1'b0;
    endcase
    step = ph_last && !((state_q == ST_EMIT) && sts_i.out_busy);
    if ((state_q == ST_LOAD) || step) ph_d = '0;
    else if (ph_last) ph_d = ph_q;
    else ph_d = ph_q + 2'd1;
  end

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    unique case (state_q)
      ST_LOAD: if (in_valid_i && in_last_i) begin
        state_d = ST_CLR;
        first_d = 1'b1;
      end
      ST_CLR:  if (step && sts_i.bkt_end) state_d = first_q ? ST_CNT : ST_SCAN;
      ST_CNT:  if (step && (sts_i.idx_end || sts_i.empty)) state_d = ST_SCAN;
      ST_SCAN: if (step && sts_i.bkt_end) begin
        state_d = ST_SCAT;
        first_d = 1'b0;
      end
      ST_SCAT: if (step && (sts_i.idx_end || sts_i.empty)) begin
        state_d = sts_i.pass_end ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: if (step && (sts_i.empty || sts_i.idx_end)) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.first = first_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CLR:  cmd_o.clr  = 1'b1;
      ST_CNT:  cmd_o.cnt  = 1'b1;
      ST_SCAN: cmd_o.scan = 1'b1;
      ST_SCAT: cmd_o.scat = 1'b1;
      ST_EMIT: cmd_o.emit = 1'b1;
      default: cmd_o = '0;
    endcase
    cmd_o.step = step;
  end
endmodule
`default_nettype wire

[src/lrs_dpath.sv]
// Datapath: key ping-pong memories, bucket tables, index counters and the
// output register. Depends on lrs_pkg.
`default_nettype none
module lrs_dpath #(
  parameter int unsigned KeysMax   = 64,
  parameter int unsigned KeyBits   = 32,
  parameter int unsigned DigitBits = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire [31:0]        in_key_i,
  input  lrs_pkg::lrs_cmd_t cmd_i,
  output lrs_pkg::lrs_sts_t sts_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [31:0]       out_key_o,
  output logic              out_last_o
);
  import lrs_pkg::*;

  localparam int unsigned Buckets = 1 << DigitBits;
  localparam int unsigned Passes  = (KeyBits + DigitBits - 1) / DigitBits;
  localparam int unsigned IdxW    = $clog2(KeysMax);
  localparam int unsigned CntW    = $clog2(KeysMax + 1);
  localparam int unsigned BktW    = DigitBits;
  localparam int unsigned PassW   = (Passes > 1) ? $clog2(Passes) : 1;
  localparam int unsigned ShW     = $clog2(DigitBits * Passes + 1);

  logic [31:0]     mem_a [KeysMax];
  logic [31:0]     mem_b [KeysMax];
  logic [CntW-1:0] tab_now  [Buckets];
  logic [CntW-1:0] tab_next [Buckets];

  logic [CntW-1:0] fill_q;
  logic [CntW:0]   idx_q;
  logic [BktW:0]   bkt_q;
  logic [PassW-1:0] pass_q;
  logic            src_b_q;
  logic [CntW-1:0] run_q;
  logic            out_valid_q;
  logic [31:0]     out_key_q;
  logic            out_last_q;
  logic [31:0]     rd_key_q;
  logic [CntW-1:0] now_rd_q;
  logic [CntW-1:0] nxt_rd_q;

  logic [IdxW-1:0] rd_idx;
  logic [BktW-1:0] d_now, d_nxt;
  logic [BktW-1:0] now_addr, nxt_addr;
  logic [CntW-1:0] scan_cnt;
  logic            more;
  logic            out_take;
  logic            act;

  function automatic logic [BktW-1:0] digit(input logic [31:0] k, input int unsigned p);
    logic [63:0] w;
    int unsigned sh;
    begin
      w  = {32'd0, k};
      sh = p * DigitBits;
      if (sh >= 32) digit = '0;
      else digit = BktW'(w >> sh);
    end
  endfunction

  assign act      = cmd_i.step;
  assign rd_idx   = idx_q[IdxW-1:0];
  assign d_now    = digit(rd_key_q, 32'(pass_q));
  assign d_nxt    = digit(rd_key_q, 32'(pass_q) + 1);
  assign now_addr = cmd_i.scan ? bkt_q[BktW-1:0] : d_now;
  assign nxt_addr = cmd_i.scan ? bkt_q[BktW-1:0] : d_nxt;
  assign scan_cnt = cmd_i.first ? now_rd_q : nxt_rd_q;
  assign more     = (32'(pass_q) + 1) < Passes;
  assign out_take = !out_valid_q || out_ready_i;

  assign sts_o.idx_end  = (idx_q[CntW-1:0] == fill_q - 1'b1) && (fill_q != '0)
                          && (!cmd_i.emit || out_take);
  assign sts_o.bkt_end  = (bkt_q == (BktW+1)'(Buckets - 1));
  assign sts_o.pass_end = !more;
  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.out_busy = !out_take;

  always_ff @(posedge clk_i) begin
    rd_key_q <= src_b_q ? mem_b[rd_idx] : mem_a[rd_idx];
    if (cmd_i.load && fill_q < CntW'(KeysMax)) mem_a[fill_q[IdxW-1:0]] <= in_key_i;
    if (cmd_i.scat && act && now_rd_q < CntW'(KeysMax)) begin
      if (src_b_q) mem_a[now_rd_q[IdxW-1:0]] <= rd_key_q;
      else         mem_b[now_rd_q[IdxW-1:0]] <= rd_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    now_rd_q <= tab_now[now_addr];
    nxt_rd_q <= tab_next[nxt_addr];
    if (act) begin
      if (cmd_i.clr) begin
        tab_next[bkt_q[BktW-1:0]] <= '0;
        if (cmd_i.first) tab_now[bkt_q[BktW-1:0]] <= '0;
      end
      if (cmd_i.cnt) tab_now[d_now] <= now_rd_q + 1'b1;
      if (cmd_i.scat) begin
        tab_now[d_now] <= now_rd_q + 1'b1;
        if (more) tab_next[d_nxt] <= nxt_rd_q + 1'b1;
      end
      if (cmd_i.scan) begin
        if (cmd_i.first) tab_now[bkt_q[BktW-1:0]] <= run_q;
        else begin
          tab_now[bkt_q[BktW-1:0]]  <= run_q;
          tab_next[bkt_q[BktW-1:0]] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      idx_q       <= '0;
      bkt_q       <= '0;
      pass_q      <= '0;
      src_b_q     <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      out_key_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (fill_q < CntW'(KeysMax)) fill_q <= fill_q + 1'b1;
        idx_q   <= '0;
        bkt_q   <= '0;
        pass_q  <= '0;
        src_b_q <= 1'b0;
        run_q   <= '0;
      end
      if (cmd_i.clr && act) begin
        bkt_q <= sts_o.bkt_end ? '0 : bkt_q + 1'b1;
        idx_q <= '0;
        run_q <= '0;
      end
      if (cmd_i.cnt && act) idx_q <= idx_q + 1'b1;
      if (cmd_i.scan && act) begin
        bkt_q <= sts_o.bkt_end ? '0 : bkt_q + 1'b1;
        run_q <= run_q + scan_cnt;
        idx_q <= '0;
      end
      if (cmd_i.scat && act) begin
        if (sts_o.idx_end || sts_o.empty) begin
          idx_q   <= '0;
          run_q   <= '0;
          src_b_q <= !src_b_q;
          if (more) pass_q <= pass_q + 1'b1;
        end else idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit && act && !sts_o.empty && out_take) begin
        out_valid_q <= 1'b1;
        out_key_q   <= rd_key_q;
        out_last_q  <= (idx_q[CntW-1:0] == fill_q - 1'b1);
        if (idx_q[CntW-1:0] == fill_q - 1'b1) begin
          fill_q <= '0;
          idx_q  <= '0;
        end else idx_q <= idx_q + 1'b1;
      end else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;

  logic unused;
  assign unused = ^{cmd_i.last_pass, ShW[0]};
endmodule
`default_nettype wire

[src/lsd_radix_sort_fused_count_core.sv]
// Top level of the LSD radix sort core: controller and datapath.
// Depends on lrs_pkg, lrs_stream_if, lrs_ctrl and lrs_dpath.
//
// Keys load one per cycle. After the key flagged last, the core clears the
// 2^DIGIT_BITS bucket tables (one entry per cycle) and counts digit 0 in one
// sweep of N keys. It then runs ceil(KEY_BITS/DIGIT_BITS) passes, each a
// prefix scan of the bucket table and a scatter that, on all but the last
// pass, also counts the next digit. Results then leave one at a time and are
// held while the output is stalled. The bucket scans dominate the sort time
// for a full set of 64 keys with 8-bit digits.
`default_nettype none
module lsd_radix_sort_fused_count_core #(
  parameter int unsigned KEYS_MAX   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned DIGIT_BITS = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  lrs_stream_if.sink   in_if,
  lrs_stream_if.source out_if
);
  import lrs_pkg::*;

  lrs_cmd_t cmd;
  lrs_sts_t sts;

  lrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.last),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrs_dpath #(
    .KeysMax   (KEYS_MAX),
    .KeyBits   (KEY_BITS),
    .DigitBits (DIGIT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_key_i    (in_if.key),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_key_o   (out_if.key),
    .out_last_o  (out_if.last)
  );
endmodule
`default_nettype wire
